[hw/rtl/prp_pkg.sv]
// Package for the page replacement policy core: policy codes, config register
// indexes, fixed field widths and the per-access decision struct.
// No dependencies.
package prp_pkg;

    localparam int MODE_W       = 2;
    localparam int FRAMES_REG_W = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int FRAME_IDX_W  = 4;
    localparam int FAULT_W      = 32;

    localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOCK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;

    localparam logic [MODE_W-1:0]       POLICY_RESET = MODE_FIFO;
    localparam logic [FRAMES_REG_W-1:0] FRAMES_RESET = 5'd16;

    typedef struct packed {
        logic hit;
        logic cold;
        logic evict;
    } t_decision;

endpackage

[hw/rtl/page_replacement_policy_core.sv]
// Page replacement core (FIFO / LRU / CLOCK) over up to FRAMES frames. Takes one
// page reference per cycle unless a held result stalls the input, and returns one
// result beat per reference via the input register and then the result register;
// between them one combinational pass does the parallel tag compare over all
// frames, lowest-empty and victim select, and the frame state update, so the next
// reference sees the state the previous one left. Config writes are taken every
// cycle; a frame count write flushes all frames, the fault count is kept.
// Depends on prp_pkg, prp_select and prp_state.
module page_replacement_policy_core #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [PAGE_BITS-1:0]             i_page_number,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_hit,
    output logic [prp_pkg::FRAME_IDX_W-1:0]  o_frame_index,
    output logic                             o_cold_fill,
    output logic                             o_evicted_valid,
    output logic [PAGE_BITS-1:0]             o_evicted_page,
    output logic [prp_pkg::FAULT_W-1:0]      o_fault_total,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [prp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int SAT_W = (CNT_W > prp_pkg::FRAMES_REG_W) ? CNT_W : prp_pkg::FRAMES_REG_W;

    logic [prp_pkg::MODE_W-1:0]       r_policy;
    logic [prp_pkg::FRAMES_REG_W-1:0] r_frames;
    logic                             r_in_valid;
    logic [PAGE_BITS-1:0]             r_in_page;
    logic                             r_out_valid;
    logic                             r_out_hit;
    logic [prp_pkg::FRAME_IDX_W-1:0]  r_out_idx;
    logic                             r_out_cold;
    logic                             r_out_evict;
    logic [PAGE_BITS-1:0]             r_out_page;
    logic [prp_pkg::FAULT_W-1:0]      r_fault;
    logic [prp_pkg::FAULT_W-1:0]      n_fault;

    logic                cfg_we;
    logic                flush;
    logic                fire;
    logic [CNT_W-1:0]    act;
    logic [FRAMES-1:0]   act_mask;
    logic [IDX_W-1:0]    last_rank;

    prp_pkg::t_decision   dec;
    logic [IDX_W-1:0]     sel_idx;
    logic [FRAMES-1:0]    ref_clear;
    logic [PAGE_BITS-1:0] victim_page;
    logic [PAGE_BITS-1:0] frame_page [FRAMES];
    logic [FRAMES-1:0]    frame_valid;
    logic [IDX_W-1:0]     frame_rank [FRAMES];
    logic [FRAMES-1:0]    ref_bit;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign flush       = cfg_we && (i_cfg_index == prp_pkg::CFG_FRAMES);

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_comb begin
        if (r_frames == '0) begin
            act = CNT_W'(1);
        end else if (SAT_W'(r_frames) > SAT_W'(FRAMES)) begin
            act = CNT_W'(FRAMES);
        end else begin
            act = CNT_W'(r_frames);
        end
        last_rank = IDX_W'(act - CNT_W'(1));
        for (int j = 0; j < FRAMES; j++) begin
            act_mask[j] = (CNT_W'(j) < act);
        end
        n_fault = r_fault;
        if (fire && dec.evict && r_fault != '1) begin
            n_fault = r_fault + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= prp_pkg::POLICY_RESET;
            r_frames    <= prp_pkg::FRAMES_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fault     <= '0;
        end else begin
            if (cfg_we && i_cfg_index == prp_pkg::CFG_POLICY) begin
                r_policy <= i_cfg_data[prp_pkg::MODE_W-1:0];
            end
            if (flush) begin
                r_frames <= i_cfg_data[prp_pkg::FRAMES_REG_W-1:0];
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_page <= i_page_number;
        end
        if (fire) begin
            r_out_hit   <= dec.hit;
            r_out_idx   <= prp_pkg::FRAME_IDX_W'(sel_idx);
            r_out_cold  <= dec.cold;
            r_out_evict <= dec.evict;
            r_out_page  <= victim_page;
        end
    end

    prp_select #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_select (
        .i_page        (r_in_page),
        .i_frame_page  (frame_page),
        .i_frame_valid (frame_valid),
        .i_frame_rank  (frame_rank),
        .i_ref_bit     (ref_bit),
        .i_act_mask    (act_mask),
        .i_last_rank   (last_rank),
        .i_mode        (r_policy),
        .o_dec         (dec),
        .o_idx         (sel_idx),
        .o_ref_clear   (ref_clear),
        .o_victim_page (victim_page)
    );

    prp_state #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_update      (fire),
        .i_flush       (flush),
        .i_dec         (dec),
        .i_idx         (sel_idx),
        .i_page        (r_in_page),
        .i_mode        (r_policy),
        .i_ref_clear   (ref_clear),
        .o_frame_page  (frame_page),
        .o_frame_valid (frame_valid),
        .o_frame_rank  (frame_rank),
        .o_ref_bit     (ref_bit)
    );

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_idx;
    assign o_cold_fill     = r_out_cold;
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_page;
    assign o_fault_total   = r_fault;

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> $onehot({dec.hit, dec.cold, dec.evict}))
        else $error("access outcome is not exactly one of hit, cold fill, evict");

    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !dec.evict |=> r_fault == $past(r_fault))
        else $error("fault count moved without an eviction");

    a_no_evict_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_page == '0)
        else $error("evicted page nonzero on a beat without eviction");

endmodule

[hw/rtl/prp_select.sv]
// Per-access lookup: parallel tag compare over the active frames, lowest-empty
// search and FIFO/LRU/CLOCK victim choice. Pure combinational.
// Depends on prp_pkg.
module prp_select #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic [PAGE_BITS-1:0]      i_page,
    input  logic [PAGE_BITS-1:0]      i_frame_page [FRAMES],
    input  logic [FRAMES-1:0]         i_frame_valid,
    input  logic [IDX_W-1:0]          i_frame_rank [FRAMES],
    input  logic [FRAMES-1:0]         i_ref_bit,
    input  logic [FRAMES-1:0]         i_act_mask,
    input  logic [IDX_W-1:0]          i_last_rank,
    input  logic [prp_pkg::MODE_W-1:0] i_mode,
    output prp_pkg::t_decision        o_dec,
    output logic [IDX_W-1:0]          o_idx,
    output logic [FRAMES-1:0]         o_ref_clear,
    output logic [PAGE_BITS-1:0]      o_victim_page
);

    function automatic logic [IDX_W-1:0] f_first(input logic [FRAMES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int j = FRAMES - 1; j >= 0; j--) begin
            if (v[j]) r = IDX_W'(j);
        end
        return r;
    endfunction

    logic [FRAMES-1:0] hit_vec;
    logic [FRAMES-1:0] empty_vec;
    logic [FRAMES-1:0] clear_vec;
    logic [FRAMES-1:0] oldest_vec;
    logic [FRAMES-1:0] below_vec;
    logic [IDX_W-1:0]  clock_idx;
    logic [IDX_W-1:0]  rank_idx;
    logic              found;
    logic              has_empty;
    logic              has_clear;

    always_comb begin
        for (int j = 0; j < FRAMES; j++) begin
            hit_vec[j]    = i_act_mask[j] & i_frame_valid[j] & (i_frame_page[j] == i_page);
            empty_vec[j]  = i_act_mask[j] & ~i_frame_valid[j];
            clear_vec[j]  = i_act_mask[j] & ~i_ref_bit[j];
            oldest_vec[j] = i_act_mask[j] & i_frame_valid[j] & (i_frame_rank[j] == i_last_rank);
        end
        found     = |hit_vec;
        has_empty = |empty_vec;
        has_clear = |clear_vec;
        clock_idx = has_clear ? f_first(clear_vec) : '0;
        rank_idx  = f_first(oldest_vec);

        for (int j = 0; j < FRAMES; j++) begin
            below_vec[j] = has_clear ? (IDX_W'(j) < clock_idx) : i_act_mask[j];
        end

        o_dec.hit   = found;
        o_dec.cold  = !found && has_empty;
        o_dec.evict = !found && !has_empty;

        if (found) begin
            o_idx = f_first(hit_vec);
        end else if (has_empty) begin
            o_idx = f_first(empty_vec);
        end else if (i_mode == prp_pkg::MODE_CLOCK) begin
            o_idx = clock_idx;
        end else begin
            o_idx = rank_idx;
        end

        o_ref_clear   = (o_dec.evict && i_mode == prp_pkg::MODE_CLOCK) ? below_vec : '0;
        o_victim_page = o_dec.evict ? i_frame_page[o_idx] : '0;
    end

endmodule

[hw/rtl/prp_state.sv]
// Frame state: page tags, valid bits, age ranks and reference bits, updated
// once per processed access; flushed on a frame count write.
// Depends on prp_pkg.
module prp_state #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_update,
    input  logic                       i_flush,
    input  prp_pkg::t_decision         i_dec,
    input  logic [IDX_W-1:0]           i_idx,
    input  logic [PAGE_BITS-1:0]       i_page,
    input  logic [prp_pkg::MODE_W-1:0] i_mode,
    input  logic [FRAMES-1:0]          i_ref_clear,
    output logic [PAGE_BITS-1:0]       o_frame_page [FRAMES],
    output logic [FRAMES-1:0]          o_frame_valid,
    output logic [IDX_W-1:0]           o_frame_rank [FRAMES],
    output logic [FRAMES-1:0]          o_ref_bit
);

    logic [PAGE_BITS-1:0] r_page [FRAMES];
    logic [FRAMES-1:0]    r_valid;
    logic [IDX_W-1:0]     r_rank [FRAMES];
    logic [FRAMES-1:0]    r_ref;

    logic [FRAMES-1:0]    n_valid;
    logic [IDX_W-1:0]     n_rank [FRAMES];
    logic [FRAMES-1:0]    n_ref;
    logic [IDX_W-1:0]     rank_limit;
    logic                 touch;
    logic                 is_self;

    always_comb begin
        touch      = !i_dec.hit || (i_mode == prp_pkg::MODE_LRU);
        rank_limit = r_valid[i_idx] ? r_rank[i_idx] : i_idx;
        for (int j = 0; j < FRAMES; j++) begin
            is_self    = (IDX_W'(j) == i_idx);
            n_valid[j] = r_valid[j];
            n_rank[j]  = r_rank[j];
            n_ref[j]   = r_ref[j];
            if (i_flush) begin
                n_valid[j] = 1'b0;
                n_rank[j]  = '0;
                n_ref[j]   = 1'b0;
            end else if (i_update) begin
                if (touch) begin
                    if (is_self) begin
                        n_rank[j] = '0;
                    end else if (r_valid[j] && r_rank[j] < rank_limit) begin
                        n_rank[j] = r_rank[j] + 1'b1;
                    end
                end
                if (!i_dec.hit) begin
                    if (is_self) begin
                        n_valid[j] = 1'b1;
                        n_ref[j]   = 1'b1;
                    end else if (i_ref_clear[j]) begin
                        n_ref[j] = 1'b0;
                    end
                end else if (is_self && i_mode == prp_pkg::MODE_CLOCK) begin
                    n_ref[j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ref   <= '0;
            for (int j = 0; j < FRAMES; j++) begin
                r_rank[j] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_ref   <= n_ref;
            for (int j = 0; j < FRAMES; j++) begin
                r_rank[j] <= n_rank[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update && !i_dec.hit) begin
            r_page[i_idx] <= i_page;
        end
    end

    assign o_frame_page  = r_page;
    assign o_frame_valid = r_valid;
    assign o_frame_rank  = r_rank;
    assign o_ref_bit     = r_ref;

endmodule

[tb/sv/page_replacement_policy_core_monitor.sv]
`timescale 1ns / 1ps
// Scoreboard for the page replacement core: tracks frame contents, ranks and
// reference bits from the observed beats and checks every result beat.
// Depends on prp_pkg.
module page_replacement_policy_core_monitor #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [PAGE_BITS-1:0]            i_page_number,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_hit,
    input  logic [prp_pkg::FRAME_IDX_W-1:0] i_frame_index,
    input  logic                            i_cold_fill,
    input  logic                            i_evicted_valid,
    input  logic [PAGE_BITS-1:0]            i_evicted_page,
    input  logic [prp_pkg::FAULT_W-1:0]     i_fault_total,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [prp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_mismatch_count,
    output int                              o_pending
);

    typedef struct packed {
        logic                            hit;
        logic [prp_pkg::FRAME_IDX_W-1:0] frame;
        logic                            cold;
        logic                            evicted;
        logic [PAGE_BITS-1:0]            evicted_page;
        logic [prp_pkg::FAULT_W-1:0]     faults;
    } t_access_result;

    logic [prp_pkg::MODE_W-1:0]       policy;
    logic [prp_pkg::FRAMES_REG_W-1:0] frames_reg;
    logic [PAGE_BITS-1:0]             res_page [FRAMES];
    logic                             res_valid [FRAMES];
    int                               res_rank [FRAMES];
    logic                             ref_bit [FRAMES];
    logic [prp_pkg::FAULT_W-1:0]      faults;
    t_access_result                   expected_accesses [$];

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        o_mismatch_count++;
    endtask

    function automatic void flush_frames();
        for (int j = 0; j < FRAMES; j++) begin
            res_page[j] = '0;
            res_valid[j] = 1'b0;
            res_rank[j] = 0;
            ref_bit[j] = 1'b0;
        end
    endfunction

    function automatic int active_frames();
        if (frames_reg == 0) return 1;
        if (frames_reg > FRAMES) return FRAMES;
        return int'(frames_reg);
    endfunction

    // Make frame k the newest; an empty frame counts as older than all valid ones.
    function automatic void promote_frame(input int k, input int act);
        int r;
        r = 0;
        if (res_valid[k]) begin
            r = res_rank[k];
        end else begin
            for (int j = 0; j < act; j++)
                if (res_valid[j]) r++;
        end
        for (int j = 0; j < act; j++)
            if (j != k && res_valid[j] && res_rank[j] < r) res_rank[j]++;
        res_rank[k] = 0;
    endfunction

    function automatic t_access_result predict_access(input logic [PAGE_BITS-1:0] page);
        t_access_result r;
        int act, slot, best;
        logic found, empty_slot, got;
        r = '0;
        act = active_frames();
        slot = 0;
        found = 1'b0;
        empty_slot = 1'b0;
        for (int j = 0; j < act; j++) begin
            if (!found && res_valid[j] && res_page[j] == page) begin
                slot = j;
                found = 1'b1;
            end
        end
        if (found) begin
            if (policy == prp_pkg::MODE_LRU) promote_frame(slot, act);
            if (policy == prp_pkg::MODE_CLOCK) ref_bit[slot] = 1'b1;
        end else begin
            for (int j = 0; j < act; j++) begin
                if (!empty_slot && !res_valid[j]) begin
                    slot = j;
                    empty_slot = 1'b1;
                end
            end
            if (!empty_slot) begin
                if (policy == prp_pkg::MODE_CLOCK) begin
                    got = 1'b0;
                    for (int j = 0; j < act; j++) begin
                        if (!got) begin
                            if (!ref_bit[j]) begin
                                slot = j;
                                got = 1'b1;
                            end else begin
                                ref_bit[j] = 1'b0;
                            end
                        end
                    end
                    if (!got) slot = 0;
                end else begin
                    best = 0;
                    slot = 0;
                    for (int j = 0; j < act; j++) begin
                        if (res_rank[j] > best) begin
                            best = res_rank[j];
                            slot = j;
                        end
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = res_page[slot];
                if (faults != '1) faults++;
            end
            r.cold = empty_slot;
            promote_frame(slot, act);
            res_page[slot] = page;
            res_valid[slot] = 1'b1;
            ref_bit[slot] = 1'b1;
        end
        r.hit = found;
        r.frame = slot[prp_pkg::FRAME_IDX_W-1:0];
        r.faults = faults;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            policy = prp_pkg::POLICY_RESET;
            frames_reg = prp_pkg::FRAMES_RESET;
            faults = '0;
            flush_frames();
            expected_accesses.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_accesses.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 64'd1, 64'd0);
                end else begin
                    want = expected_accesses.pop_front();
                    if (i_hit !== want.hit) report_mismatch("hit", 64'(i_hit), 64'(want.hit));
                    if (i_frame_index !== want.frame)
                        report_mismatch("frame_index", 64'(i_frame_index), 64'(want.frame));
                    if (i_cold_fill !== want.cold)
                        report_mismatch("cold_fill", 64'(i_cold_fill), 64'(want.cold));
                    if (i_evicted_valid !== want.evicted)
                        report_mismatch("evicted_valid", 64'(i_evicted_valid),
                                        64'(want.evicted));
                    if (i_evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", 64'(i_evicted_page),
                                        64'(want.evicted_page));
                    if (i_fault_total !== want.faults)
                        report_mismatch("fault_total", 64'(i_fault_total), 64'(want.faults));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    prp_pkg::CFG_POLICY: policy = i_cfg_data[prp_pkg::MODE_W-1:0];
                    prp_pkg::CFG_FRAMES: begin
                        frames_reg = i_cfg_data;
                        flush_frames();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_accesses.push_back(predict_access(i_page_number));
        end
        o_pending <= expected_accesses.size();
    end

endmodule

[tb/sv/page_replacement_policy_core_tb.sv]
`timescale 1ns / 1ps
// Top of the page replacement core testbench: clock, reset, reference stream,
// config writes, result back-pressure, watchdog and verdict.
// Depends on prp_pkg, page_replacement_policy_core and its monitor.
module page_replacement_policy_core_tb;

    localparam int FRAMES       = 16;
    localparam int PAGE_BITS    = 16;
    localparam int PHASES       = 17;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [prp_pkg::CFG_IDX_W-1:0]  CFG_UNMAPPED      = 2'd2;
    localparam logic [prp_pkg::CFG_DATA_W-1:0] POLICY_CODE_SPARE = 5'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [PAGE_BITS-1:0]            page_number = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            hit;
    logic [prp_pkg::FRAME_IDX_W-1:0] frame_index;
    logic                            cold_fill;
    logic                            evicted_valid;
    logic [PAGE_BITS-1:0]            evicted_page;
    logic [prp_pkg::FAULT_W-1:0]     fault_total;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [prp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [prp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    int                              mismatches;
    int                              pending;
    int                              idle_cycles = 0;
    bit                              hold_request = 1'b0;
    bit                              steady_sender = 1'b0;

    always #6 clk = ~clk;

    page_replacement_policy_core #(
        .FRAMES   (FRAMES),
        .PAGE_BITS(PAGE_BITS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_page_number  (page_number),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_hit          (hit),
        .o_frame_index  (frame_index),
        .o_cold_fill    (cold_fill),
        .o_evicted_valid(evicted_valid),
        .o_evicted_page (evicted_page),
        .o_fault_total  (fault_total),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    page_replacement_policy_core_monitor #(
        .FRAMES   (FRAMES),
        .PAGE_BITS(PAGE_BITS)
    ) access_monitor (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_page_number   (page_number),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_hit           (hit),
        .i_frame_index   (frame_index),
        .i_cold_fill     (cold_fill),
        .i_evicted_valid (evicted_valid),
        .i_evicted_page  (evicted_page),
        .i_fault_total   (fault_total),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatch_count(mismatches),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int pick;
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_request && !hold_taken) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_taken = 1'b1;
            end else if (pick < 40) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end else if (pick < 88) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else if (pick < 97) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end else begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 90) return $urandom_range(1, 2);
        if (p < 97) return $urandom_range(3, 6);
        return $urandom_range(15, 50);
    endfunction

    function automatic logic [PAGE_BITS-1:0] next_page(input logic [PAGE_BITS-1:0] base,
                                                       input int span);
        logic [PAGE_BITS-1:0] page;
        page = PAGE_BITS'($urandom);
        if ($urandom_range(0, 99) < 85) page = base + PAGE_BITS'($urandom_range(0, span - 1));
        return page;
    endfunction

    task automatic send_page(input logic [PAGE_BITS-1:0] page);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        page_number <= page;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [prp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int phase, n, frames_val, active, span, pick;
        logic [PAGE_BITS-1:0] base;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // FIFO over three frames: cold fills, a hit, then oldest-load evictions
        write_reg(prp_pkg::CFG_FRAMES, 5'd3);
        write_reg(prp_pkg::CFG_POLICY, prp_pkg::CFG_DATA_W'(prp_pkg::MODE_FIFO));
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hAAAA);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'h0000);
        quiesce();
        // switch to LRU with contents kept
        write_reg(prp_pkg::CFG_POLICY, prp_pkg::CFG_DATA_W'(prp_pkg::MODE_LRU));
        send_page(16'hAAAA);
        send_page(16'h1234);
        send_page(16'h5555);
        quiesce();
        // CLOCK with every reference bit set: sweep clears all, frame 0 taken
        write_reg(prp_pkg::CFG_POLICY, prp_pkg::CFG_DATA_W'(prp_pkg::MODE_CLOCK));
        send_page(16'h8000);
        send_page(16'h0001);
        send_page(16'h8000);
        send_page(16'h7FFF);
        quiesce();
        write_reg(prp_pkg::CFG_POLICY, POLICY_CODE_SPARE);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        quiesce();
        // frame count of zero acts as a single frame
        write_reg(prp_pkg::CFG_FRAMES, 5'd0);
        send_page(16'h0007);
        send_page(16'h0007);
        send_page(16'h0008);
        quiesce();
        // oversized frame count saturates; unmapped index is ignored
        write_reg(prp_pkg::CFG_FRAMES, 5'd31);
        write_reg(CFG_UNMAPPED, 5'd31);
        send_page(16'h0003);
        send_page(16'h0003);
        quiesce();

        active = FRAMES;
        for (phase = 0; phase < PHASES; phase++) begin
            quiesce();
            pick = $urandom_range(0, 9);
            if (phase == 0) frames_val = 1;
            else if (phase == 1) frames_val = FRAMES;
            else if (pick == 0) frames_val = 0;
            else if (pick == 1) frames_val = 31;
            else if (pick == 2) frames_val = $urandom_range(FRAMES + 1, 31);
            else if (pick == 3) frames_val = FRAMES;
            else frames_val = $urandom_range(1, FRAMES);
            if (phase < 2 || $urandom_range(0, 3) != 0) begin
                write_reg(prp_pkg::CFG_FRAMES, frames_val[prp_pkg::CFG_DATA_W-1:0]);
                active = (frames_val == 0) ? 1 : (frames_val > FRAMES) ? FRAMES : frames_val;
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(prp_pkg::CFG_POLICY, prp_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            else
                write_reg(prp_pkg::CFG_POLICY, prp_pkg::CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0)
                write_reg(prp_pkg::CFG_IDX_W'(CFG_UNMAPPED + $urandom_range(0, 1)),
                          prp_pkg::CFG_DATA_W'($urandom));

            steady_sender = (phase == 2) || (phase % 5 == 3);
            if (phase == 2) hold_request = 1'b1;
            span = active + $urandom_range(0, active);
            base = PAGE_BITS'($urandom);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4 && n == PHASE_ITEMS / 2) quiesce();
                if (n % 25 == 24 && $urandom_range(0, 1) == 1)
                    base = base + PAGE_BITS'($urandom_range(1, span));
                send_page(next_page(base, span));
            end
        end
        steady_sender = 1'b0;
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
